// ===== rtl/coverage_redundancy_statistics_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COVERAGE_REDUNDANCY_STATISTICS_DEFINES_SVH
`define COVERAGE_REDUNDANCY_STATISTICS_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Consequent checked in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

// ===== rtl/crs_pkg.sv =====
`default_nettype none
package crs_pkg;

    localparam int MAX_METERS  = 4096;
    localparam int COUNT_BITS  = 16;
    localparam int ADDR_W      = $clog2(MAX_METERS);

    localparam int CFG_W       = 13;
    localparam int IDX_W       = 12;
    localparam int OUT_CNT_W   = 16;
    localparam int MEAN_W      = 24;
    localparam int TOTAL_W     = 32;
    localparam int FRAC_BITS   = 8;

    localparam int DVD_W       = TOTAL_W + FRAC_BITS;
    localparam int REM_W       = CFG_W + 1;
    localparam int DIV_CNT_W   = $clog2(DVD_W + 1);

    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 2 * OUT_CNT_W + MEAN_W + TOTAL_W;

    localparam logic [CFG_W-1:0] METER_COUNT_RESET = 13'd4096;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic item_wr;
        logic sweep_start;
        logic sweep_step;
        logic div_start;
        logic div_step;
        logic out_load;
    } crs_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last_entry;
        logic sweep_end;
        logic div_done;
        logic out_free;
    } crs_status_t;

endpackage
`default_nettype wire

// ===== rtl/crs_datapath.sv =====
`default_nettype none
module crs_datapath
    import crs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_has,
    input  logic                  in_last,
    input  crs_cmd_t              cmd,
    output crs_status_t           status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_error
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [TOTAL_W-1:0]    TOT_MAX = '1;
    localparam logic [ADDR_W-1:0]     ADDR_LAST = ADDR_W'(MAX_METERS - 1);

    function automatic logic [OUT_CNT_W-1:0] cap_count(input logic [COUNT_BITS-1:0] v);
        logic [OUT_CNT_W-1:0] lim;
        lim = '1;
        if (64'(v) > 64'(lim))
            return lim;
        return OUT_CNT_W'(v);
    endfunction

    logic [CFG_W-1:0]      meter_count_reg;
    logic [CFG_W-1:0]      n_eff;

    logic [IDX_W-1:0]      idx_reg;
    logic                  has_reg;
    logic                  last_reg;

    logic [COUNT_BITS-1:0] mem [MAX_METERS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     mem_addr;
    logic                  mem_we;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] cnt_inc;

    logic [ADDR_W-1:0]     sweep_addr_reg;
    logic                  rd_vld_reg;
    logic                  sweep_inr;
    logic                  item_inr;
    logic                  item_hit;

    logic [TOTAL_W-1:0]    total_reg;
    logic                  err_reg;
    logic [TOTAL_W-1:0]    tot_snap_reg;
    logic                  err_snap_reg;
    logic [COUNT_BITS-1:0] lo_reg;
    logic [COUNT_BITS-1:0] hi_reg;

    logic [DVD_W-1:0]      dvd_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      n_ext;
    logic                  q_bit;

    logic                  n_zero;
    logic [MEAN_W-1:0]     mean_sat;
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_err_reg;

    // meter count limited to the store depth
    assign n_eff = (32'(meter_count_reg) > 32'(MAX_METERS)) ? CFG_W'(MAX_METERS)
                                                            : meter_count_reg;
    assign n_zero = (n_eff == '0);

    assign item_inr  = (CFG_W'(idx_reg) < n_eff);
    assign item_hit  = cmd.item_wr && has_reg && item_inr;
    assign sweep_inr = (32'(sweep_addr_reg) < 32'(n_eff));

    assign cnt_inc   = (rd_data_reg == CNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
    assign mem_addr  = cmd.sweep_step ? sweep_addr_reg : ADDR_W'(idx_reg);
    assign mem_we    = item_hit || cmd.sweep_step;
    assign mem_wdata = cmd.sweep_step ? '0 : cnt_inc;

    // restoring divider, one quotient bit per step
    assign n_ext  = REM_W'(n_eff);
    assign rem_sh = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign q_bit  = (rem_sh >= n_ext);

    assign mean_sat = (|dvd_reg[DVD_W-1:MEAN_W]) ? '1 : dvd_reg[MEAN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_count_reg <= METER_COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            meter_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg  <= in_data[IDX_W-1:0];
            has_reg  <= in_has;
            last_reg <= in_last;
        end
    end

    // read-first: a sweep reads the old count while clearing it
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_addr_reg <= '0;
            rd_vld_reg     <= 1'b0;
            total_reg      <= '0;
            err_reg        <= 1'b0;
            div_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.sweep_step && sweep_inr;

            if (cmd.sweep_start)
            begin
                sweep_addr_reg <= '0;
                total_reg      <= '0;
                err_reg        <= 1'b0;
            end
            else
            begin
                if (cmd.sweep_step)
                begin
                    sweep_addr_reg <= sweep_addr_reg + 1'b1;
                end
                if (item_hit && (total_reg != TOT_MAX))
                begin
                    total_reg <= total_reg + 1'b1;
                end
                if (cmd.item_wr && has_reg && !item_inr)
                begin
                    err_reg <= 1'b1;
                end
            end

            if (cmd.div_start)
            begin
                div_cnt_reg <= DIV_CNT_W'(DVD_W);
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_start)
        begin
            tot_snap_reg <= total_reg;
            err_snap_reg <= err_reg;
            lo_reg       <= CNT_MAX;
            hi_reg       <= '0;
        end
        else if (rd_vld_reg)
        begin
            if (rd_data_reg < lo_reg)
            begin
                lo_reg <= rd_data_reg;
            end
            if (rd_data_reg > hi_reg)
            begin
                hi_reg <= rd_data_reg;
            end
        end

        if (cmd.div_start)
        begin
            dvd_reg <= {tot_snap_reg, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], q_bit};
            rem_reg <= q_bit ? (rem_sh - n_ext) : rem_sh;
        end

        if (cmd.out_load)
        begin
            out_err_reg <= err_snap_reg;
            if (n_zero)
            begin
                out_data_reg <= {tot_snap_reg, {MEAN_W{1'b0}}, {(2 * OUT_CNT_W){1'b0}}};
            end
            else
            begin
                out_data_reg <= {tot_snap_reg, mean_sat, cap_count(hi_reg),
                                 cap_count(lo_reg)};
            end
        end
    end

    assign status.last_entry = last_reg;
    assign status.sweep_end  = (sweep_addr_reg == ADDR_LAST);
    assign status.div_done   = (div_cnt_reg == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_error = out_err_reg;

endmodule
`default_nettype wire

// ===== rtl/crs_ctrl.sv =====
`default_nettype none
module crs_ctrl
    import crs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  crs_status_t status,
    output crs_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SWEEP_INIT,
        ST_SWEEP,
        ST_DRAIN,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_end)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.item_wr = 1'b1;
                state_next  = status.last_entry ? ST_SWEEP_INIT : ST_IDLE;
            end
            ST_SWEEP_INIT:
            begin
                cmd.sweep_start = 1'b1;
                state_next      = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last read word lands in min/max this cycle
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_OUT;
                else
                    cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/coverage_redundancy_statistics.sv =====
// Channel        | Dir | Payload
// s_axis         | in  | tdata: meter_index; tuser: has_entry; tlast: last_entry
// m_axis         | out | tdata: min_count, max_count, mean_q8, entry_total; tuser: index_error
// cfg_wr         | in  | cfg_wr_data: meter_count, written when cfg_wr_en is high
//
// An entry item goes through three steps: accept, counter read, counter write.
// A last item adds a sweep setup, a counter sweep over all MAX_METERS entries (read and
// clear) on the single counter RAM port, a drain, 40 steps of the bit-serial divider, a
// check that the divider is done, and an output load.
// After reset the counter RAM is swept to zero over all MAX_METERS entries; s_axis_tready
// stays low until that pass ends.
// The result sits in an output register; new items are taken while it waits. The next
// last item holds in the output load until that register is free.
`default_nettype none
module coverage_redundancy_statistics
    import crs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,    // meter_count
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [11:0] meter_index, rest zero
    input  logic                  s_axis_tuser,   // [0] has_entry
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // min_count, max_count, mean_q8, entry_total
    output logic                  m_axis_tuser    // [0] index_error
);

    crs_cmd_t    cmd;
    crs_status_t status;

    crs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_axis_tdata),
        .in_has      (s_axis_tuser),
        .in_last     (s_axis_tlast),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_error   (m_axis_tuser)
    );

endmodule
`default_nettype wire

// ===== rtl/crs_checker.sv =====
`default_nettype none
`include "coverage_redundancy_statistics_defines.svh"
module crs_checker
    import crs_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // a stalled result stays offered
    `CRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // a stalled result keeps its payload
    `CRS_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // one item at a time: ready drops right after an accept
    `CRS_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // min never exceeds max
    `CRS_ASSERT_SAME(a_min_le_max, m_axis_tvalid,
                     m_axis_tdata[OUT_CNT_W-1:0] <= m_axis_tdata[2*OUT_CNT_W-1:OUT_CNT_W])

endmodule

bind coverage_redundancy_statistics crs_checker u_crs_checker (.*);
`default_nettype wire
